// File: src/gfqq_pkg.sv
package gfqq_pkg;

   localparam int NUM_GROUPS  = 4;
   localparam int GROUP_DEPTH = 16;
   localparam int VALUE_BITS  = 16;

   localparam int GRP_IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int ORD_CNT_W = $clog2(NUM_GROUPS + 1);
   localparam int PTR_W     = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
   localparam int CNT_W     = $clog2(GROUP_DEPTH + 1);
   localparam int ADDR_W    = $clog2(NUM_GROUPS * GROUP_DEPTH);

   localparam int GROUP_W   = 3;
   localparam int FIELD_W   = 16;
   localparam int DATA_W    = 24;

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   typedef enum logic [2:0] {
      ST_ENQ    = 3'd0,
      ST_DEQ    = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_FULL   = 3'd3,
      ST_BADGRP = 3'd4
   } status_type;

   typedef struct packed {
      status_type              status;
      logic [GROUP_W-1:0]      group;
      logic [ADDR_W-1:0]       addr;
      logic                    wr_en;
      logic                    rd_en;
      logic [VALUE_BITS-1:0]   wdata;
   } op_type;

endpackage

// File: src/gfqq_sched.sv
module gfqq_sched (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        req_type,
   input  logic [gfqq_pkg::GROUP_W-1:0] group_id,
   input  logic [gfqq_pkg::FIELD_W-1:0] item_value,
   output gfqq_pkg::op_type            op
);

   logic [gfqq_pkg::PTR_W-1:0]     group_head_ff  [gfqq_pkg::NUM_GROUPS];
   logic [gfqq_pkg::CNT_W-1:0]     group_count_ff [gfqq_pkg::NUM_GROUPS];
   logic [gfqq_pkg::GRP_IDX_W-1:0] order_ids_ff   [gfqq_pkg::NUM_GROUPS];
   logic [gfqq_pkg::GRP_IDX_W-1:0] order_head_ff, order_head_in;
   logic [gfqq_pkg::ORD_CNT_W-1:0] order_count_ff, order_count_in;

   logic [gfqq_pkg::GRP_IDX_W-1:0] enq_idx, deq_idx, sel_idx, ord_widx;
   logic [gfqq_pkg::PTR_W-1:0]     sel_head, head_in;
   logic [gfqq_pkg::CNT_W-1:0]     sel_count, count_in;
   logic                           grp_we, ord_we, bad_group;
   logic [gfqq_pkg::PTR_W:0]       slot_sum;
   logic [gfqq_pkg::PTR_W-1:0]     slot;
   logic [gfqq_pkg::GRP_IDX_W:0]   tail_sum;
   logic [gfqq_pkg::PTR_W-1:0]     head_inc;
   logic [gfqq_pkg::GRP_IDX_W-1:0] order_head_inc;

   assign enq_idx   = gfqq_pkg::GRP_IDX_W'(group_id - 3'd1);
   assign deq_idx   = order_ids_ff[order_head_ff];
   assign bad_group = (group_id == '0) || (int'(group_id) > gfqq_pkg::NUM_GROUPS);
   assign sel_idx   = (req_type == gfqq_pkg::REQ_ENQ) ? enq_idx : deq_idx;
   assign sel_head  = group_head_ff[sel_idx];
   assign sel_count = group_count_ff[sel_idx];

   // tail slot of the group fifo, wrapped
   assign slot_sum = (gfqq_pkg::PTR_W+1)'(sel_head) + (gfqq_pkg::PTR_W+1)'(sel_count);
   assign slot     = (int'(slot_sum) >= gfqq_pkg::GROUP_DEPTH)
                   ? gfqq_pkg::PTR_W'(slot_sum - (gfqq_pkg::PTR_W+1)'(gfqq_pkg::GROUP_DEPTH))
                   : gfqq_pkg::PTR_W'(slot_sum);
   assign head_inc = (int'(sel_head) == gfqq_pkg::GROUP_DEPTH - 1)
                   ? '0 : sel_head + 1'b1;

   // tail of the order ring, wrapped
   assign tail_sum = (gfqq_pkg::GRP_IDX_W+1)'(order_head_ff)
                   + (gfqq_pkg::GRP_IDX_W+1)'(order_count_ff);
   assign ord_widx = (int'(tail_sum) >= gfqq_pkg::NUM_GROUPS)
                   ? gfqq_pkg::GRP_IDX_W'(tail_sum
                        - (gfqq_pkg::GRP_IDX_W+1)'(gfqq_pkg::NUM_GROUPS))
                   : gfqq_pkg::GRP_IDX_W'(tail_sum);
   assign order_head_inc = (int'(order_head_ff) == gfqq_pkg::NUM_GROUPS - 1)
                         ? '0 : order_head_ff + 1'b1;

   always_comb begin
      op.status      = gfqq_pkg::ST_ENQ;
      op.group       = '0;
      op.addr        = gfqq_pkg::ADDR_W'(sel_idx) * gfqq_pkg::ADDR_W'(gfqq_pkg::GROUP_DEPTH);
      op.wr_en       = 1'b0;
      op.rd_en       = 1'b0;
      op.wdata       = gfqq_pkg::VALUE_BITS'(item_value);
      grp_we         = 1'b0;
      ord_we         = 1'b0;
      head_in        = sel_head;
      count_in       = sel_count;
      order_head_in  = order_head_ff;
      order_count_in = order_count_ff;
      if (req_type == gfqq_pkg::REQ_ENQ) begin
         priority if (bad_group) begin
            op.status = gfqq_pkg::ST_BADGRP;
         end else if (int'(sel_count) >= gfqq_pkg::GROUP_DEPTH) begin
            op.status = gfqq_pkg::ST_FULL;
         end else begin
            if (sel_count == '0 && int'(order_count_ff) < gfqq_pkg::NUM_GROUPS) begin
               ord_we         = 1'b1;
               order_count_in = order_count_ff + 1'b1;
            end
            op.addr  = op.addr + gfqq_pkg::ADDR_W'(slot);
            op.wr_en = 1'b1;
            grp_we   = 1'b1;
            count_in = sel_count + 1'b1;
         end
      end else begin
         priority if (order_count_ff == '0) begin
            op.status = gfqq_pkg::ST_EMPTY;
         end else if (sel_count == '0) begin
            // stale order entry: drop it
            op.status      = gfqq_pkg::ST_EMPTY;
            order_head_in  = order_head_inc;
            order_count_in = order_count_ff - 1'b1;
         end else begin
            op.status = gfqq_pkg::ST_DEQ;
            op.group  = gfqq_pkg::GROUP_W'(sel_idx) + 3'd1;
            op.addr   = op.addr + gfqq_pkg::ADDR_W'(sel_head);
            op.rd_en  = 1'b1;
            grp_we    = 1'b1;
            head_in   = head_inc;
            count_in  = sel_count - 1'b1;
            if (sel_count == gfqq_pkg::CNT_W'(1)) begin
               order_head_in  = order_head_inc;
               order_count_in = order_count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gfqq_pkg::NUM_GROUPS; i++) begin
            group_head_ff[i]  <= '0;
            group_count_ff[i] <= '0;
         end
         order_head_ff  <= '0;
         order_count_ff <= '0;
      end else if (advance) begin
         if (grp_we) begin
            group_head_ff[sel_idx]  <= head_in;
            group_count_ff[sel_idx] <= count_in;
         end
         order_head_ff  <= order_head_in;
         order_count_ff <= order_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ord_we) begin
         order_ids_ff[ord_widx] <= enq_idx;
      end
   end

endmodule

// File: src/grouped_fifo_queue_of_queues_unit.sv
// Queue of queues over four groups. A request transfer either enqueues a value to the
// group it names (1 to 4) or dequeues from the group that became non-empty earliest;
// every request gives exactly one response transfer with a status: enqueued, dequeued,
// empty, group full or bad group. One request is taken every cycle unless response
// backpressure holds a request in the input register; a request passes through the input
// register and then the response stage, which presents the response and whose value comes
// from the registered read port of the single-port value store. Backpressure on the
// response side stalls both stages in place.
module grouped_fifo_queue_of_queues_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // group_id, item_value, zero fill
   input  logic [0:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_group, out_value, zero fill
   output logic [2:0]  rsp_tuser   // status
);

   logic                             in_valid_ff;
   logic                             in_type_ff;
   logic [gfqq_pkg::GROUP_W-1:0]     in_group_ff;
   logic [gfqq_pkg::FIELD_W-1:0]     in_value_ff;

   logic                             out_valid_ff;
   gfqq_pkg::status_type             out_status_ff;
   logic [gfqq_pkg::GROUP_W-1:0]     out_group_ff;
   logic [gfqq_pkg::VALUE_BITS-1:0]  store_rd_ff;

   logic [gfqq_pkg::VALUE_BITS-1:0]  store_mem [gfqq_pkg::NUM_GROUPS * gfqq_pkg::GROUP_DEPTH];

   logic            out_free, advance;
   gfqq_pkg::op_type op;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   gfqq_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_type   (in_type_ff),
      .group_id   (in_group_ff),
      .item_value (in_value_ff),
      .op         (op)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_type_ff  <= req_tuser[0];
         in_group_ff <= req_tdata[2:0];
         in_value_ff <= req_tdata[18:3];
      end
      if (advance) begin
         out_status_ff <= op.status;
         out_group_ff  <= op.group;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (op.wr_en) begin
            store_mem[op.addr] <= op.wdata;
         end else if (op.rd_en) begin
            store_rd_ff <= store_mem[op.addr];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {5'b0,
                        (out_status_ff == gfqq_pkg::ST_DEQ)
                           ? gfqq_pkg::FIELD_W'(store_rd_ff) : {gfqq_pkg::FIELD_W{1'b0}},
                        (out_status_ff == gfqq_pkg::ST_DEQ)
                           ? out_group_ff : {gfqq_pkg::GROUP_W{1'b0}}};

endmodule

// File: src/gfqq_checker.sv
module gfqq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // no value unless dequeued
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != gfqq_pkg::ST_DEQ |-> rsp_tdata == '0)
      else $error("value on non-dequeue response");

   // a dequeue names a real group
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == gfqq_pkg::ST_DEQ |->
         rsp_tdata[2:0] != 3'd0 && int'(rsp_tdata[2:0]) <= gfqq_pkg::NUM_GROUPS)
      else $error("dequeue with bad group");

   // reset empties the response stage
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind grouped_fifo_queue_of_queues_unit gfqq_checker u_gfqq_checker (.*);

// File: tb/gfqq_reply_checker.sv
`timescale 1ns / 1ps
module gfqq_reply_checker
   import gfqq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,  // group_id, item_value, zero fill
   input  logic [0:0]  req_tuser,  // req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,  // out_group, out_value, zero fill
   input  logic [2:0]  rsp_tuser,  // status
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      status_type            status;
      logic [GROUP_W-1:0]    group;
      logic [VALUE_BITS-1:0] value;
   } reply_type;

   logic [VALUE_BITS-1:0] grp_values [NUM_GROUPS][GROUP_DEPTH];
   int                    grp_front  [NUM_GROUPS];
   int                    grp_fill   [NUM_GROUPS];
   int                    order_ring [NUM_GROUPS];
   int                    order_front;
   int                    order_fill;
   reply_type             due_replies [$];
   int                    mismatches;

   initial begin
      fail_count = 0;
      pending    = 0;
      mismatches = 0;
   end

   function automatic reply_type serve_request(input logic kind,
                                               input logic [GROUP_W-1:0] gid,
                                               input logic [VALUE_BITS-1:0] val);
      reply_type r;
      int        g;
      r.status = ST_ENQ;
      r.group  = '0;
      r.value  = '0;
      if (kind == REQ_ENQ) begin
         if (gid == 0 || gid > NUM_GROUPS) begin
            r.status = ST_BADGRP;
         end else begin
            g = int'(gid) - 1;
            if (grp_fill[g] >= GROUP_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // a group joins the order ring when it turns non-empty
               if (grp_fill[g] == 0 && order_fill < NUM_GROUPS) begin
                  order_ring[(order_front + order_fill) % NUM_GROUPS] = g;
                  order_fill++;
               end
               grp_values[g][(grp_front[g] + grp_fill[g]) % GROUP_DEPTH] = val;
               grp_fill[g]++;
            end
         end
      end else begin
         if (order_fill == 0) begin
            r.status = ST_EMPTY;
         end else begin
            g = order_ring[order_front];
            if (grp_fill[g] == 0) begin
               order_front = (order_front + 1) % NUM_GROUPS;
               order_fill--;
               r.status = ST_EMPTY;
            end else begin
               r.status     = ST_DEQ;
               r.group      = GROUP_W'(g + 1);
               r.value      = grp_values[g][grp_front[g]];
               grp_front[g] = (grp_front[g] + 1) % GROUP_DEPTH;
               grp_fill[g]--;
               if (grp_fill[g] == 0) begin
                  order_front = (order_front + 1) % NUM_GROUPS;
                  order_fill--;
               end
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_front[g]  = 0;
            grp_fill[g]   = 0;
            order_ring[g] = 0;
         end
         order_front = 0;
         order_fill  = 0;
         due_replies.delete();
      end else begin
         if (req_tvalid && req_tready)
            due_replies.push_back(serve_request(req_tuser[0], req_tdata[2:0],
                                                req_tdata[18:3]));
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.group  = rsp_tdata[2:0];
            got.value  = rsp_tdata[18:3];
            if (due_replies.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response: status %0d group %0d value %h",
                           got.status, got.group, got.value);
               mismatches++;
            end else begin
               want = due_replies.pop_front();
               if (want.status != got.status || want.group != got.group ||
                   want.value != got.value) begin
                  if (mismatches < 10)
                     $display("mismatch: status exp %0d got %0d, group exp %0d got %0d, value exp %h got %h",
                              want.status, got.status, want.group, got.group,
                              want.value, got.value);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= due_replies.size();
   end

endmodule

// File: tb/grouped_fifo_queue_of_queues_unit_tb.sv
`timescale 1ns / 1ps
module grouped_fifo_queue_of_queues_unit_tb;

   localparam int LIMIT        = 200000;
   localparam int HOLD_CYCLES  = 60;
   localparam int PHASE_ITEMS  = 160;

   typedef enum int {FILL_MIX, DRAIN_MIX, EVEN_MIX, ONE_GROUP} burst_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // group_id, item_value, zero fill
   logic [0:0]  req_tuser  = '0;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // out_group, out_value, zero fill
   logic [2:0]  rsp_tuser;        // status

   int   send_idle_pct  = 0;
   int   sink_stall_pct = 0;
   logic hold_req       = 1'b0;
   int   cycles         = 0;
   int   fail_count;
   int   pending;

   always #5 clock = ~clock;

   grouped_fifo_queue_of_queues_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   gfqq_reply_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("grouped_fifo_queue_of_queues_unit_tb: done, errors");
         $finish;
      end
   end

   // response side: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   task automatic send_item(input logic kind, input logic [gfqq_pkg::GROUP_W-1:0] gid,
                            input logic [gfqq_pkg::VALUE_BITS-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, val, gid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_burst(input burst_kind_type mode, input int n);
      int                              enq_pct;
      logic                            kind;
      logic [gfqq_pkg::GROUP_W-1:0]    gid;
      logic [gfqq_pkg::GROUP_W-1:0]    focus;
      logic [gfqq_pkg::VALUE_BITS-1:0] val;
      case (mode)
         FILL_MIX:  enq_pct = 85;
         DRAIN_MIX: enq_pct = 20;
         EVEN_MIX:  enq_pct = 50;
         default:   enq_pct = 90;
      endcase
      focus = gfqq_pkg::GROUP_W'($urandom_range(1, gfqq_pkg::NUM_GROUPS));
      for (int i = 0; i < n; i++) begin
         kind = ($urandom_range(99) < enq_pct) ? gfqq_pkg::REQ_ENQ : gfqq_pkg::REQ_DEQ;
         if ($urandom_range(9) == 0)
            gid = gfqq_pkg::GROUP_W'($urandom_range(7));
         else if (mode == ONE_GROUP)
            gid = focus;
         else
            gid = gfqq_pkg::GROUP_W'($urandom_range(1, gfqq_pkg::NUM_GROUPS));
         val = gfqq_pkg::VALUE_BITS'($urandom);
         send_item(kind, gid, val);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int idle_by_phase  [4];
      int stall_by_phase [4];
      int sent;
      int n;
      idle_by_phase  = '{0, 62, 0, 31};
      stall_by_phase = '{0, 0, 62, 31};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty, bad groups, extremes, ordering, re-entry
      send_item(gfqq_pkg::REQ_DEQ, 3'd7, 16'hFFFF);
      send_item(gfqq_pkg::REQ_ENQ, 3'd0, 16'h1234);
      send_item(gfqq_pkg::REQ_ENQ, 3'd5, 16'hFFFF);
      send_item(gfqq_pkg::REQ_ENQ, 3'd7, 16'h0000);
      send_item(gfqq_pkg::REQ_ENQ, 3'd3, 16'hFFFF);
      send_item(gfqq_pkg::REQ_ENQ, 3'd1, 16'h0000);
      send_item(gfqq_pkg::REQ_ENQ, 3'd3, 16'h0001);
      send_item(gfqq_pkg::REQ_ENQ, 3'd4, 16'h8000);
      send_item(gfqq_pkg::REQ_ENQ, 3'd2, 16'h7FFF);
      repeat (5) send_item(gfqq_pkg::REQ_DEQ, 3'd0, 16'h0000);
      send_item(gfqq_pkg::REQ_DEQ, 3'd0, 16'h0000);
      send_item(gfqq_pkg::REQ_ENQ, 3'd3, 16'hA5A5);
      send_item(gfqq_pkg::REQ_ENQ, 3'd1, 16'h5A5A);
      send_item(gfqq_pkg::REQ_DEQ, 3'd2, 16'hFFFF);
      send_item(gfqq_pkg::REQ_ENQ, 3'd3, 16'h0F0F);
      repeat (3) send_item(gfqq_pkg::REQ_DEQ, 3'd0, 16'h0000);
      send_item(gfqq_pkg::REQ_DEQ, 3'd0, 16'h0000);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_by_phase[p];
         sink_stall_pct = stall_by_phase[p];
         sent = 0;
         if (p == 0) begin
            hold_req = 1'b1;
            send_burst(FILL_MIX, 20);
            sent = 20;
         end
         while (sent < PHASE_ITEMS) begin
            n = $urandom_range(10, 30);
            send_burst(burst_kind_type'($urandom_range(0, 3)), n);
            sent += n;
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("grouped_fifo_queue_of_queues_unit_tb: done, clean");
      else
         $display("grouped_fifo_queue_of_queues_unit_tb: done, errors");
      $finish;
   end

endmodule
